>>> sv/crs_pkg.sv
// Shared types, codes and defaults for the command schedule retry sequencer.
package crs_pkg;

  localparam int DEF_QUEUE_DEPTH = 16;

  localparam int WORD_W    = 16;
  localparam int TIME_W    = 32;
  localparam int CNT_W     = 4;
  localparam int CMD_W     = 3;
  localparam int CFG_IDX_W = 3;
  localparam int ENTRY_W   = 2 * WORD_W;

  localparam logic [CMD_W-1:0] CMD_APPEND   = 3'd0;
  localparam logic [CMD_W-1:0] CMD_POLL     = 3'd1;
  localparam logic [CMD_W-1:0] CMD_RESPONSE = 3'd2;
  localparam logic [CMD_W-1:0] CMD_SENT     = 3'd3;
  localparam logic [CMD_W-1:0] CMD_RESET    = 3'd4;

  localparam logic [CFG_IDX_W-1:0] CFG_START_CODE  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_END_CODE    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ACK_MASK    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT_MS  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_RESEND  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_RESTART = 3'd5;

  localparam logic [WORD_W-1:0] DEF_START_CODE  = 16'd255;
  localparam logic [WORD_W-1:0] DEF_END_CODE    = 16'd254;
  localparam logic [WORD_W-1:0] DEF_ACK_MASK    = 16'd256;
  localparam logic [WORD_W-1:0] DEF_TIMEOUT_MS  = 16'd1000;
  localparam logic [CNT_W-1:0]  DEF_MAX_RESEND  = 4'd3;
  localparam logic [CNT_W-1:0]  DEF_MAX_RESTART = 4'd3;

  typedef enum logic [2:0] {
    PH_EMPTY     = 3'd0,
    PH_SCHEDULED = 3'd1,
    PH_SEND      = 3'd2,
    PH_SENT      = 3'd3,
    PH_ERROR     = 3'd4
  } phase_t;

  typedef struct packed {
    logic [WORD_W-1:0] start_code;
    logic [WORD_W-1:0] end_code;
    logic [WORD_W-1:0] ack_mask;
    logic [WORD_W-1:0] timeout_ms;
    logic [CNT_W-1:0]  max_resend;
    logic [CNT_W-1:0]  max_restart;
  } cfg_t;

  typedef struct packed {
    phase_t            phase;
    logic [TIME_W-1:0] start_time;
    logic [CNT_W-1:0]  resend_cnt;
    logic [CNT_W-1:0]  restart_cnt;
    logic              in_config;
    logic [WORD_W-1:0] tail_cmd;
  } ctl_t;

endpackage

>>> sv/command_schedule_retry_sequencer.sv
// Data path: the input transfer loads the input register; a step then updates the state
//   registers once the result slot is free, and the result is valid after that update.
// Throughput: one item per cycle while results are taken; the state update is combinational
//   logic from the input register into the state registers and the registered queue bank read.
// Reset (rst_n, synchronous, active low): queue empty, counters and timer zero, phase empty,
//   configuration registers to defaults; queue contents are not cleared.
module command_schedule_retry_sequencer #(
  parameter int QUEUE_DEPTH = crs_pkg::DEF_QUEUE_DEPTH,
  localparam int PW         = $clog2(QUEUE_DEPTH + 1)
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [crs_pkg::CMD_W-1:0]      in_command,
  input  logic [crs_pkg::WORD_W-1:0]     in_cmd_word,
  input  logic [crs_pkg::WORD_W-1:0]     in_sub_word,
  input  logic [crs_pkg::TIME_W-1:0]     in_time_now,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [2:0]                     out_sched_state,
  output logic [crs_pkg::WORD_W-1:0]     out_active_cmd,
  output logic [crs_pkg::WORD_W-1:0]     out_active_sub,
  output logic [PW-1:0]                  out_active_index,
  output logic [PW-1:0]                  out_queued_count,
  output logic                           out_config_active,
  input  logic                           cfg_we,
  input  logic [crs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [crs_pkg::WORD_W-1:0]     cfg_wdata
);

  crs_pkg::cfg_t               cfg_r;
  logic                        item_valid_r;
  logic [crs_pkg::CMD_W-1:0]   item_cmd_r;
  logic [crs_pkg::WORD_W-1:0]  item_cw_r;
  logic [crs_pkg::WORD_W-1:0]  item_sw_r;
  logic [crs_pkg::TIME_W-1:0]  item_t_r;
  logic                        out_valid_r;
  logic                        step_go;

  logic [PW-1:0]               fill_r;
  logic [PW-1:0]               pos_r;
  crs_pkg::ctl_t               ctl_r;
  logic [PW-1:0]               fill_nxt;
  logic [PW-1:0]               pos_nxt;
  crs_pkg::ctl_t               ctl_nxt;

  logic                        we_even;
  logic [PW-1:0]               pos_even;
  logic [crs_pkg::ENTRY_W-1:0] data_even;
  logic                        we_odd;
  logic [PW-1:0]               pos_odd;
  logic [crs_pkg::ENTRY_W-1:0] data_odd;
  logic [crs_pkg::ENTRY_W-1:0] act_word;

  assign step_go  = item_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !item_valid_r || step_go;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.start_code  <= crs_pkg::DEF_START_CODE;
      cfg_r.end_code    <= crs_pkg::DEF_END_CODE;
      cfg_r.ack_mask    <= crs_pkg::DEF_ACK_MASK;
      cfg_r.timeout_ms  <= crs_pkg::DEF_TIMEOUT_MS;
      cfg_r.max_resend  <= crs_pkg::DEF_MAX_RESEND;
      cfg_r.max_restart <= crs_pkg::DEF_MAX_RESTART;
    end else if (cfg_we) begin
      case (cfg_index)
        crs_pkg::CFG_START_CODE:  cfg_r.start_code  <= cfg_wdata;
        crs_pkg::CFG_END_CODE:    cfg_r.end_code    <= cfg_wdata;
        crs_pkg::CFG_ACK_MASK:    cfg_r.ack_mask    <= cfg_wdata;
        crs_pkg::CFG_TIMEOUT_MS:  cfg_r.timeout_ms  <= cfg_wdata;
        crs_pkg::CFG_MAX_RESEND:  cfg_r.max_resend  <= cfg_wdata[crs_pkg::CNT_W-1:0];
        crs_pkg::CFG_MAX_RESTART: cfg_r.max_restart <= cfg_wdata[crs_pkg::CNT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_valid_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      item_valid_r <= 1'b1;
    end else if (step_go) begin
      item_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_cmd_r <= in_command;
      item_cw_r  <= in_cmd_word;
      item_sw_r  <= in_sub_word;
      item_t_r   <= in_time_now;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (step_go) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // state changes only on a step, and a step needs the result slot free, so it also
  // serves as the result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r            <= '0;
      pos_r             <= '0;
      ctl_r.phase       <= crs_pkg::PH_EMPTY;
      ctl_r.start_time  <= '0;
      ctl_r.resend_cnt  <= '0;
      ctl_r.restart_cnt <= '0;
      ctl_r.in_config   <= 1'b0;
      ctl_r.tail_cmd    <= '0;
    end else if (step_go) begin
      fill_r <= fill_nxt;
      pos_r  <= pos_nxt;
      ctl_r  <= ctl_nxt;
    end
  end

  crs_step #(
    .DEPTH (QUEUE_DEPTH),
    .PW    (PW)
  ) u_step (
    .item_cmd  (item_cmd_r),
    .item_cw   (item_cw_r),
    .item_sw   (item_sw_r),
    .item_t    (item_t_r),
    .cfg       (cfg_r),
    .fill      (fill_r),
    .pos       (pos_r),
    .ctl       (ctl_r),
    .act_cmd   (act_word[crs_pkg::ENTRY_W-1:crs_pkg::WORD_W]),
    .fill_nxt  (fill_nxt),
    .pos_nxt   (pos_nxt),
    .ctl_nxt   (ctl_nxt),
    .we_even   (we_even),
    .pos_even  (pos_even),
    .data_even (data_even),
    .we_odd    (we_odd),
    .pos_odd   (pos_odd),
    .data_odd  (data_odd)
  );

  crs_qmem #(
    .DEPTH (QUEUE_DEPTH),
    .PW    (PW)
  ) u_qmem (
    .clk       (clk),
    .we_even   (we_even && step_go),
    .pos_even  (pos_even),
    .data_even (data_even),
    .we_odd    (we_odd && step_go),
    .pos_odd   (pos_odd),
    .data_odd  (data_odd),
    .rd_en     (step_go),
    .rd_pos    (pos_nxt),
    .rd_word   (act_word)
  );

  assign out_valid         = out_valid_r;
  assign out_sched_state   = ctl_r.phase;
  assign out_active_cmd    = act_word[crs_pkg::ENTRY_W-1:crs_pkg::WORD_W];
  assign out_active_sub    = act_word[crs_pkg::WORD_W-1:0];
  assign out_active_index  = pos_r;
  assign out_queued_count  = fill_r;
  assign out_config_active = ctl_r.in_config;

endmodule

>>> sv/crs_qmem.sv
// Command queue storage: even/odd banks, one write each, registered read with bypass.
module crs_qmem #(
  parameter int DEPTH = crs_pkg::DEF_QUEUE_DEPTH,
  parameter int PW    = $clog2(DEPTH + 1)
) (
  input  logic                         clk,
  input  logic                         we_even,
  input  logic [PW-1:0]                pos_even,
  input  logic [crs_pkg::ENTRY_W-1:0]  data_even,
  input  logic                         we_odd,
  input  logic [PW-1:0]                pos_odd,
  input  logic [crs_pkg::ENTRY_W-1:0]  data_odd,
  input  logic                         rd_en,
  input  logic [PW-1:0]                rd_pos,
  output logic [crs_pkg::ENTRY_W-1:0]  rd_word
);

  localparam int BANK_DEPTH = (DEPTH + 1) / 2;
  localparam int BANK_AW    = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;

  logic [crs_pkg::ENTRY_W-1:0] bank_even [BANK_DEPTH];
  logic [crs_pkg::ENTRY_W-1:0] bank_odd  [BANK_DEPTH];

  logic [BANK_AW-1:0]          idx_even;
  logic [BANK_AW-1:0]          idx_odd;
  logic [BANK_AW-1:0]          idx_rd;
  logic [crs_pkg::ENTRY_W-1:0] even_q_r;
  logic [crs_pkg::ENTRY_W-1:0] odd_q_r;
  logic                        sel_odd_r;

  assign idx_even = pos_even[BANK_AW:1];
  assign idx_odd  = pos_odd[BANK_AW:1];
  assign idx_rd   = rd_pos[BANK_AW:1];

  always_ff @(posedge clk) begin
    if (we_even) begin
      bank_even[idx_even] <= data_even;
    end
    if (we_odd) begin
      bank_odd[idx_odd] <= data_odd;
    end
    if (rd_en) begin
      sel_odd_r <= rd_pos[0];
      even_q_r  <= (we_even && idx_even == idx_rd) ? data_even : bank_even[idx_rd];
      odd_q_r   <= (we_odd && idx_odd == idx_rd) ? data_odd : bank_odd[idx_rd];
    end
  end

  assign rd_word = sel_odd_r ? odd_q_r : even_q_r;

endmodule

>>> sv/crs_step.sv
// Next-state logic for one item: append, poll with retry/restart, response, sent, reset.
module crs_step #(
  parameter int DEPTH = crs_pkg::DEF_QUEUE_DEPTH,
  parameter int PW    = $clog2(DEPTH + 1)
) (
  input  logic [crs_pkg::CMD_W-1:0]    item_cmd,
  input  logic [crs_pkg::WORD_W-1:0]   item_cw,
  input  logic [crs_pkg::WORD_W-1:0]   item_sw,
  input  logic [crs_pkg::TIME_W-1:0]   item_t,
  input  crs_pkg::cfg_t                cfg,
  input  logic [PW-1:0]                fill,
  input  logic [PW-1:0]                pos,
  input  crs_pkg::ctl_t                ctl,
  input  logic [crs_pkg::WORD_W-1:0]   act_cmd,
  output logic [PW-1:0]                fill_nxt,
  output logic [PW-1:0]                pos_nxt,
  output crs_pkg::ctl_t                ctl_nxt,
  output logic                         we_even,
  output logic [PW-1:0]                pos_even,
  output logic [crs_pkg::ENTRY_W-1:0]  data_even,
  output logic                         we_odd,
  output logic [PW-1:0]                pos_odd,
  output logic [crs_pkg::ENTRY_W-1:0]  data_odd
);

  always_comb begin : step_p
    logic                        at_tail;
    logic                        app;
    logic                        inc;
    logic                        exec_end;
    logic [crs_pkg::WORD_W-1:0]  app_c;
    logic [crs_pkg::WORD_W-1:0]  app_s;
    logic [crs_pkg::TIME_W-1:0]  deadline;

    fill_nxt  = fill;
    pos_nxt   = pos;
    ctl_nxt   = ctl;
    we_even   = 1'b0;
    pos_even  = fill;
    data_even = '0;
    we_odd    = 1'b0;
    pos_odd   = fill;
    data_odd  = '0;
    app       = 1'b0;
    inc       = 1'b0;
    exec_end  = 1'b0;
    app_c     = item_cw;
    app_s     = item_sw;
    at_tail   = (fill != '0) && (pos >= fill - 1'b1);
    deadline  = ctl.start_time + {{(crs_pkg::TIME_W - crs_pkg::WORD_W){1'b0}}, cfg.timeout_ms};

    case (item_cmd)
      crs_pkg::CMD_APPEND: begin
        app = 1'b1;
      end
      crs_pkg::CMD_POLL: begin
        case (ctl.phase)
          crs_pkg::PH_SCHEDULED: begin
            ctl_nxt.start_time  = item_t;
            ctl_nxt.resend_cnt  = '0;
            ctl_nxt.restart_cnt = '0;
          end
          crs_pkg::PH_SENT: begin
            if (item_t > deadline) begin
              if (ctl.resend_cnt < cfg.max_resend) begin
                ctl_nxt.start_time = item_t;
                ctl_nxt.resend_cnt = ctl.resend_cnt + 1'b1;
                ctl_nxt.phase      = crs_pkg::PH_SEND;
              end else if (ctl.restart_cnt < cfg.max_restart) begin
                pos_nxt             = '0;
                ctl_nxt.start_time  = item_t;
                ctl_nxt.resend_cnt  = '0;
                ctl_nxt.restart_cnt = ctl.restart_cnt + 1'b1;
                ctl_nxt.phase       = crs_pkg::PH_SCHEDULED;
              end else begin
                fill_nxt            = '0;
                pos_nxt             = '0;
                ctl_nxt.start_time  = item_t;
                ctl_nxt.resend_cnt  = '0;
                ctl_nxt.restart_cnt = '0;
                ctl_nxt.phase       = crs_pkg::PH_ERROR;
              end
            end
          end
          crs_pkg::PH_EMPTY: begin
            if (at_tail && ctl.in_config) begin
              app   = 1'b1;
              app_c = cfg.end_code;
              app_s = '0;
            end else if (at_tail) begin
              fill_nxt            = '0;
              pos_nxt             = '0;
              ctl_nxt.start_time  = item_t;
              ctl_nxt.resend_cnt  = '0;
              ctl_nxt.restart_cnt = '0;
              ctl_nxt.phase       = crs_pkg::PH_EMPTY;
            end
          end
          default: begin
          end
        endcase
      end
      crs_pkg::CMD_RESPONSE: begin
        if (item_cw == (act_cmd | cfg.ack_mask)) begin
          if (item_cw == (cfg.start_code | cfg.ack_mask)) begin
            ctl_nxt.in_config = 1'b1;
          end else if (item_cw == (cfg.end_code | cfg.ack_mask)) begin
            ctl_nxt.in_config = 1'b0;
          end
          if (at_tail && ctl_nxt.in_config) begin
            app   = 1'b1;
            app_c = cfg.end_code;
            app_s = '0;
            inc   = 1'b1;
          end else if (at_tail) begin
            fill_nxt            = '0;
            pos_nxt             = '0;
            ctl_nxt.start_time  = item_t;
            ctl_nxt.resend_cnt  = '0;
            ctl_nxt.restart_cnt = '0;
            ctl_nxt.phase       = crs_pkg::PH_EMPTY;
          end else begin
            inc = 1'b1;
          end
        end
      end
      crs_pkg::CMD_SENT: begin
        if (ctl.phase == crs_pkg::PH_SCHEDULED || ctl.phase == crs_pkg::PH_SEND) begin
          ctl_nxt.start_time = item_t;
          ctl_nxt.phase      = crs_pkg::PH_SENT;
          ctl_nxt.in_config  = 1'b1;
        end
      end
      crs_pkg::CMD_RESET: begin
        fill_nxt            = '0;
        pos_nxt             = '0;
        ctl_nxt.start_time  = item_t;
        ctl_nxt.resend_cnt  = '0;
        ctl_nxt.restart_cnt = '0;
        ctl_nxt.phase       = crs_pkg::PH_EMPTY;
      end
      default: begin
      end
    endcase

    // append: error when full, else trailing config-end handling, implicit config-start, then the entry
    if (app) begin
      if (fill_nxt >= PW'(DEPTH)) begin
        fill_nxt            = '0;
        pos_nxt             = '0;
        ctl_nxt.start_time  = item_t;
        ctl_nxt.resend_cnt  = '0;
        ctl_nxt.restart_cnt = '0;
        ctl_nxt.phase       = crs_pkg::PH_ERROR;
      end else begin
        if (fill_nxt == '0) begin
          exec_end = (app_c != cfg.start_code);
        end else if (ctl_nxt.tail_cmd == cfg.end_code) begin
          exec_end = (pos_nxt == fill_nxt - 1'b1) &&
                     (ctl_nxt.phase != crs_pkg::PH_SCHEDULED) &&
                     (app_c != cfg.start_code);
          fill_nxt = fill_nxt - 1'b1;
        end
        if (exec_end) begin
          if (fill_nxt[0]) begin
            we_odd   = 1'b1;
            pos_odd  = fill_nxt;
            data_odd = {cfg.start_code, {crs_pkg::WORD_W{1'b0}}};
          end else begin
            we_even   = 1'b1;
            pos_even  = fill_nxt;
            data_even = {cfg.start_code, {crs_pkg::WORD_W{1'b0}}};
          end
          if (ctl_nxt.phase == crs_pkg::PH_EMPTY) begin
            ctl_nxt.phase = crs_pkg::PH_SCHEDULED;
          end
          fill_nxt         = fill_nxt + 1'b1;
          ctl_nxt.tail_cmd = cfg.start_code;
        end
        if (fill_nxt[0]) begin
          we_odd   = 1'b1;
          pos_odd  = fill_nxt;
          data_odd = {app_c, app_s};
        end else begin
          we_even   = 1'b1;
          pos_even  = fill_nxt;
          data_even = {app_c, app_s};
        end
        if (ctl_nxt.phase == crs_pkg::PH_EMPTY) begin
          ctl_nxt.phase = crs_pkg::PH_SCHEDULED;
        end
        fill_nxt         = fill_nxt + 1'b1;
        ctl_nxt.tail_cmd = app_c;
      end
    end

    // advance to the next entry after an acknowledged command
    if (inc) begin
      pos_nxt       = pos_nxt + 1'b1;
      ctl_nxt.phase = crs_pkg::PH_SCHEDULED;
      if (pos_nxt >= PW'(DEPTH)) begin
        fill_nxt            = '0;
        pos_nxt             = '0;
        ctl_nxt.start_time  = item_t;
        ctl_nxt.resend_cnt  = '0;
        ctl_nxt.restart_cnt = '0;
        ctl_nxt.phase       = crs_pkg::PH_EMPTY;
      end
    end
  end

endmodule
